@@ hdl/scc_pkg.sv @@
// Package: opcode codes, float predicate table and result type for the scalar compare unit.
`timescale 1ns / 1ps
package scc_pkg;

  localparam logic [5:0] FN_SET_IDX  = 6'd0;
  localparam logic [5:0] FN_NOP_A    = 6'd1;
  localparam logic [5:0] FN_NOP_B    = 6'd2;
  localparam logic [5:0] FN_EQ_U64   = 6'd3;
  localparam logic [5:0] FN_LG_U64   = 6'd4;
  localparam logic [5:0] FN_BC0_B32  = 6'd5;
  localparam logic [5:0] FN_BC1_B32  = 6'd6;
  localparam logic [5:0] FN_BC0_B64  = 6'd7;
  localparam logic [5:0] FN_BC1_B64  = 6'd8;
  localparam logic [5:0] FN_GT_I32   = 6'd9;
  localparam logic [5:0] FN_LT_I32   = 6'd10;
  localparam logic [5:0] FN_GE_I32   = 6'd11;
  localparam logic [5:0] FN_LE_I32   = 6'd12;
  localparam logic [5:0] FN_EQ_U32   = 6'd13;
  localparam logic [5:0] FN_LG_U32   = 6'd14;
  localparam logic [5:0] FN_GE_U32   = 6'd15;
  localparam logic [5:0] FN_GT_U32   = 6'd16;
  localparam logic [5:0] FN_LT_U32   = 6'd17;
  localparam logic [5:0] FN_LE_U32   = 6'd18;
  localparam logic [5:0] FN_EQ_I32   = 6'd19;
  localparam logic [5:0] FN_LG_I32   = 6'd20;
  localparam logic [5:0] FN_F32_BASE = 6'd21;
  localparam logic [5:0] FN_F16_BASE = 6'd35;
  localparam logic [5:0] FN_LAST     = 6'd48;

  localparam logic [5:0] SHAMT64_MASK = 6'h3F;
  localparam logic [5:0] SHAMT32_MASK = 6'h1F;

  // relation bits: {gt, eq, lt, unordered}
  typedef logic [3:0] rel_t;
  localparam rel_t REL_UN = 4'h1;
  localparam rel_t REL_LT = 4'h2;
  localparam rel_t REL_EQ = 4'h4;
  localparam rel_t REL_GT = 4'h8;

  function automatic rel_t fpred(input logic [3:0] idx);
    rel_t r;
    r = 4'h0;
    unique case (idx)
      4'd0:    r = 4'h4;
      4'd1:    r = 4'hA;
      4'd2:    r = 4'h8;
      4'd3:    r = 4'hC;
      4'd4:    r = 4'h2;
      4'd5:    r = 4'h6;
      4'd6:    r = 4'hB;
      4'd7:    r = 4'hD;
      4'd8:    r = 4'h9;
      4'd9:    r = 4'h7;
      4'd10:   r = 4'h3;
      4'd11:   r = 4'h5;
      4'd12:   r = 4'hE;
      4'd13:   r = 4'h1;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        handled;
    logic        scc_write;
    logic        scc_value;
    logic        m0_write;
    logic [31:0] m0_value;
  } res_t;

endpackage

@@ hdl/scalar_compare_scc_unit.sv @@
// Scalar compare unit: one compare instruction in, one SCC/M0 write result out.
// From start to out_valid an item passes two registers: the input register, then the result register.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The work is one pass of comparators between the input and result registers.
// Reset (synchronous, rst_n low) clears the valid flags; no result appears after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module scalar_compare_scc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_func,
  input  logic [63:0] in_src0,
  input  logic [63:0] in_src1,
  output logic        out_valid,
  output logic        out_handled,
  output logic        out_scc_write,
  output logic        out_scc_value,
  output logic        out_m0_write,
  output logic [31:0] out_m0_value
);

  logic        vld_r;
  logic [5:0]  func_r;
  logic [63:0] s0_r, s1_r;
  logic        ovld_r;
  scc_pkg::res_t res_r, res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= start;
      ovld_r <= vld_r;
    end
    if (start) begin
      func_r <= in_func;
      s0_r   <= in_src0;
      s1_r   <= in_src1;
    end
    if (vld_r) res_r <= res_nxt;
  end

  // IEEE relation on raw bits; half selects 16-bit operands, else 32-bit
  function automatic scc_pkg::rel_t fp_rel(input logic [31:0] a, input logic [31:0] b,
                                           input logic half);
    logic        na, nb, sa, sb;
    logic [30:0] ma, mb;
    scc_pkg::rel_t r;
    if (half) begin
      na = (a[14:10] == 5'h1F) && (a[9:0] != 10'h0);
      nb = (b[14:10] == 5'h1F) && (b[9:0] != 10'h0);
      sa = a[15];
      sb = b[15];
      ma = {16'h0, a[14:0]};
      mb = {16'h0, b[14:0]};
    end else begin
      na = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
      nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
      sa = a[31];
      sb = b[31];
      ma = a[30:0];
      mb = b[30:0];
    end
    if (na || nb)                         r = scc_pkg::REL_UN;
    else if (ma == 31'h0 && mb == 31'h0)  r = scc_pkg::REL_EQ;
    else if (sa != sb)                    r = sa ? scc_pkg::REL_LT : scc_pkg::REL_GT;
    else if (ma == mb)                    r = scc_pkg::REL_EQ;
    else if ((ma < mb) ^ sa)              r = scc_pkg::REL_LT;
    else                                  r = scc_pkg::REL_GT;
    return r;
  endfunction

  logic [31:0]   a, b;
  logic          bit32, bit64, scc;
  scc_pkg::rel_t rel;
  logic [5:0]    fidx;

  always_comb begin
    a     = s0_r[31:0];
    b     = s1_r[31:0];
    bit32 = a[b[4:0] & scc_pkg::SHAMT32_MASK[4:0]];
    bit64 = s0_r[b[5:0] & scc_pkg::SHAMT64_MASK];
    rel   = fp_rel(a, b, func_r >= scc_pkg::FN_F16_BASE);
    fidx  = (func_r >= scc_pkg::FN_F16_BASE) ? func_r - scc_pkg::FN_F16_BASE
                                             : func_r - scc_pkg::FN_F32_BASE;
    scc = 1'b0;
    unique case (func_r)
      scc_pkg::FN_EQ_U64:  scc = s0_r == s1_r;
      scc_pkg::FN_LG_U64:  scc = s0_r != s1_r;
      scc_pkg::FN_BC0_B32: scc = !bit32;
      scc_pkg::FN_BC1_B32: scc = bit32;
      scc_pkg::FN_BC0_B64: scc = !bit64;
      scc_pkg::FN_BC1_B64: scc = bit64;
      scc_pkg::FN_GT_I32:  scc = $signed(a) > $signed(b);
      scc_pkg::FN_LT_I32:  scc = $signed(a) < $signed(b);
      scc_pkg::FN_GE_I32:  scc = $signed(a) >= $signed(b);
      scc_pkg::FN_LE_I32:  scc = $signed(a) <= $signed(b);
      scc_pkg::FN_EQ_U32:  scc = a == b;
      scc_pkg::FN_LG_U32:  scc = a != b;
      scc_pkg::FN_GE_U32:  scc = a >= b;
      scc_pkg::FN_GT_U32:  scc = a > b;
      scc_pkg::FN_LT_U32:  scc = a < b;
      scc_pkg::FN_LE_U32:  scc = a <= b;
      scc_pkg::FN_EQ_I32:  scc = a == b;
      scc_pkg::FN_LG_I32:  scc = a != b;
      default:             scc = (scc_pkg::fpred(fidx[3:0]) & rel) != 4'h0;
    endcase

    res_nxt = '0;
    if (func_r == scc_pkg::FN_SET_IDX) begin
      res_nxt.handled  = 1'b1;
      res_nxt.m0_write = 1'b1;
      res_nxt.m0_value = a;
    end else if (func_r == scc_pkg::FN_NOP_A || func_r == scc_pkg::FN_NOP_B) begin
      res_nxt.handled = 1'b1;
    end else if (func_r <= scc_pkg::FN_LAST) begin
      res_nxt.handled   = 1'b1;
      res_nxt.scc_write = 1'b1;
      res_nxt.scc_value = scc;
    end
  end

  assign out_valid     = ovld_r;
  assign out_handled   = res_r.handled;
  assign out_scc_write = res_r.scc_write;
  assign out_scc_value = res_r.scc_value;
  assign out_m0_write  = res_r.m0_write;
  assign out_m0_value  = res_r.m0_value;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> out_valid) else $error("accepted item lost");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_scc_write && out_m0_write)) else $error("scc and m0 both written");
  a_unh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_handled |-> !out_scc_write && !out_m0_write)
    else $error("unhandled opcode writes");
  a_sv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scc_value |-> out_scc_write) else $error("scc value without write");

endmodule

@@ sim/testbench.sv @@
// Testbench for the scalar compare unit: directed and random compares checked against a predictor.
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  in_func = '0;
  logic [63:0] in_src0 = '0;
  logic [63:0] in_src1 = '0;
  logic        out_valid;
  logic        out_handled;
  logic        out_scc_write;
  logic        out_scc_value;
  logic        out_m0_write;
  logic [31:0] out_m0_value;

  scc_pkg::res_t pending_res[$];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  bit          no_idle = 1'b0;

  localparam int CYCLE_LIMIT = 200000;

  scalar_compare_scc_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_src0(in_src0), .in_src1(in_src1),
    .out_valid(out_valid), .out_handled(out_handled),
    .out_scc_write(out_scc_write), .out_scc_value(out_scc_value),
    .out_m0_write(out_m0_write), .out_m0_value(out_m0_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL scalar_compare_scc_unit");
      $finish;
    end
  end

  // IEEE relation from raw bits; w is the total width (16 or 32)
  function automatic scc_pkg::rel_t float_rel(input logic [31:0] a, input logic [31:0] b,
                                              input int w);
    logic [31:0] mag_a, mag_b, emask, mmask;
    logic        nan_a, nan_b;
    longint      ka, kb;
    mag_a = (w == 32) ? {1'b0, a[30:0]} : {17'b0, a[14:0]};
    mag_b = (w == 32) ? {1'b0, b[30:0]} : {17'b0, b[14:0]};
    emask = (w == 32) ? 32'h7F80_0000 : 32'h7C00;
    mmask = (w == 32) ? 32'h007F_FFFF : 32'h03FF;
    nan_a = ((a & emask) == emask) && ((a & mmask) != 0);
    nan_b = ((b & emask) == emask) && ((b & mmask) != 0);
    if (nan_a || nan_b) return scc_pkg::REL_UN;
    if (mag_a == 0 && mag_b == 0) return scc_pkg::REL_EQ;
    ka = a[w-1] ? -longint'(mag_a) : longint'(mag_a);
    kb = b[w-1] ? -longint'(mag_b) : longint'(mag_b);
    if (ka < kb) return scc_pkg::REL_LT;
    if (ka > kb) return scc_pkg::REL_GT;
    return scc_pkg::REL_EQ;
  endfunction

  function automatic scc_pkg::rel_t pred_set(input int idx);
    case (idx)
      0: return 4'h4;  1: return 4'hA;  2: return 4'h8;  3: return 4'hC;
      4: return 4'h2;  5: return 4'h6;  6: return 4'hB;  7: return 4'hD;
      8: return 4'h9;  9: return 4'h7;  10: return 4'h3; 11: return 4'h5;
      12: return 4'hE; default: return 4'h1;
    endcase
  endfunction

  function automatic scc_pkg::res_t compare_result(input logic [5:0] fn,
                                                   input logic [63:0] s0,
                                                   input logic [63:0] s1);
    scc_pkg::res_t r;
    logic [31:0]   a, b;
    logic          c;
    a = s0[31:0];
    b = s1[31:0];
    c = 1'b0;
    r = '0;
    r.handled = 1'b1;
    r.scc_write = 1'b1;
    if (fn == scc_pkg::FN_SET_IDX) begin
      r.scc_write = 1'b0;
      r.m0_write = 1'b1;
      r.m0_value = a;
    end else if (fn == scc_pkg::FN_NOP_A || fn == scc_pkg::FN_NOP_B) begin
      r.scc_write = 1'b0;
    end else if (fn > scc_pkg::FN_LAST) begin
      r.handled = 1'b0;
      r.scc_write = 1'b0;
    end else begin
      case (fn)
        scc_pkg::FN_EQ_U64:  c = (s0 == s1);
        scc_pkg::FN_LG_U64:  c = (s0 != s1);
        scc_pkg::FN_BC0_B32: c = !a[b[4:0]];
        scc_pkg::FN_BC1_B32: c = a[b[4:0]];
        scc_pkg::FN_BC0_B64: c = !s0[b[5:0]];
        scc_pkg::FN_BC1_B64: c = s0[b[5:0]];
        scc_pkg::FN_GT_I32:  c = $signed(a) > $signed(b);
        scc_pkg::FN_LT_I32:  c = $signed(a) < $signed(b);
        scc_pkg::FN_GE_I32:  c = $signed(a) >= $signed(b);
        scc_pkg::FN_LE_I32:  c = $signed(a) <= $signed(b);
        scc_pkg::FN_EQ_U32, scc_pkg::FN_EQ_I32: c = (a == b);
        scc_pkg::FN_LG_U32, scc_pkg::FN_LG_I32: c = (a != b);
        scc_pkg::FN_GE_U32:  c = a >= b;
        scc_pkg::FN_GT_U32:  c = a > b;
        scc_pkg::FN_LT_U32:  c = a < b;
        scc_pkg::FN_LE_U32:  c = a <= b;
        default: begin
          if (fn < scc_pkg::FN_F16_BASE)
            c = (pred_set(int'(fn - scc_pkg::FN_F32_BASE)) & float_rel(a, b, 32)) != 0;
          else
            c = (pred_set(int'(fn - scc_pkg::FN_F16_BASE)) &
                 float_rel({16'b0, a[15:0]}, {16'b0, b[15:0]}, 16)) != 0;
        end
      endcase
      r.scc_value = c;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    scc_pkg::res_t want;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_res.pop_front();
        if (out_handled !== want.handled)
          report_mismatch("handled", 32'(out_handled), 32'(want.handled));
        if (out_scc_write !== want.scc_write)
          report_mismatch("scc_write", 32'(out_scc_write), 32'(want.scc_write));
        if (out_scc_value !== want.scc_value)
          report_mismatch("scc_value", 32'(out_scc_value), 32'(want.scc_value));
        if (out_m0_write !== want.m0_write)
          report_mismatch("m0_write", 32'(out_m0_write), 32'(want.m0_write));
        if (out_m0_value !== want.m0_value)
          report_mismatch("m0_value", out_m0_value, want.m0_value);
      end
    end
  end

  // hold start until the item is taken; idle between items at random
  task automatic send_item(input logic [5:0] fn, input logic [63:0] s0, input logic [63:0] s1);
    while (!no_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_src0 <= s0;
    in_src1 <= s1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_res.push_back(compare_result(fn, s0, s1));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand drawn half the time from float-interesting patterns in the low bits
  function automatic logic [63:0] rand_operand(input bit half);
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = half ? {16'h0, 1'($urandom_range(1)), 15'h7C00}
                  : {1'($urandom_range(1)), 31'h7F80_0000};
      1: v = half ? {16'h0, 1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023, 1))}
                  : {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7FFFFF, 1))};
      2: v = half ? {16'h0, 1'($urandom_range(1)), 15'h0}
                  : {1'($urandom_range(1)), 31'h0};
      3: v = half ? {16'h0, 1'($urandom_range(1)), 5'h0, 10'($urandom())}
                  : {1'($urandom_range(1)), 8'h0, 23'($urandom())};
      default: v = $urandom();
    endcase
    return {$urandom(), half ? {16'($urandom()), v[15:0]} : v};
  endfunction

  task automatic test_extremes();
    send_item(scc_pkg::FN_SET_IDX, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(scc_pkg::FN_SET_IDX, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(scc_pkg::FN_NOP_A, rand64(), rand64());
    send_item(scc_pkg::FN_NOP_B, rand64(), rand64());
    send_item(scc_pkg::FN_EQ_U64, 64'h1_0000_0000, 64'h0);
    send_item(scc_pkg::FN_LG_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(scc_pkg::FN_BC1_B32, 64'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(scc_pkg::FN_BC0_B64, 64'h8000_0000_0000_0000, 64'h3F);
    send_item(scc_pkg::FN_GT_I32, 64'h7FFF_FFFF, 64'h8000_0000);
    send_item(scc_pkg::FN_GT_U32, 64'h7FFF_FFFF, 64'h8000_0000);
    send_item(scc_pkg::FN_F32_BASE, 64'h8000_0000, 64'h0);            // -0 == +0
    send_item(6'(scc_pkg::FN_F32_BASE + 13), 64'h7FC0_0000, 64'h0);   // unordered
    send_item(6'(scc_pkg::FN_F32_BASE + 12), 64'h7F80_0000, 64'hFF80_0000);
    send_item(6'(scc_pkg::FN_F32_BASE + 4), 64'h0000_0001, 64'h8000_0001); // denormals
    send_item(scc_pkg::FN_F16_BASE, 64'hFFFF_0000_8000, 64'h0);
    send_item(6'(scc_pkg::FN_F16_BASE + 6), 64'h7E00, 64'h3C00);
    send_item(6'(scc_pkg::FN_F16_BASE + 2), 64'h0001, 64'h8001);
    send_item(6'd49, rand64(), rand64());
    send_item(6'd63, rand64(), rand64());
    go_idle();
  endtask

  task automatic test_all_opcodes();
    for (int f = 0; f < 64; f++) send_item(6'(f), rand64(), rand64());
    go_idle();
  endtask

  task automatic test_random(input int count);
    logic [5:0]  fn;
    logic [63:0] s0, s1;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 2 && i < count / 2 + 300);
      fn = (i % 16 == 0) ? 6'($urandom_range(63, 49)) : 6'($urandom_range(48));
      s0 = rand_operand(fn >= scc_pkg::FN_F16_BASE);
      s1 = (i % 5 == 0) ? s0 : rand_operand(fn >= scc_pkg::FN_F16_BASE);
      if (i % 7 == 0) s1[63:32] = $urandom();
      send_item(fn, s0, s1);
    end
    no_idle = 1'b0;
    go_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_all_opcodes();
    test_random(1750);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS scalar_compare_scc_unit");
    end else begin
      $display("FAIL scalar_compare_scc_unit");
    end
    $finish;
  end

endmodule
